// ===== design/tilt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_pkg: shared constants and types for the tilt angle pipeline
// Fixed-point formats, CORDIC step angles, pi and the degree divisor.
// ----------------------------------------------------------------------------
package tilt_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 60;
    localparam int NORM_STAGES     = 6;
    localparam int ROOT_STEPS      = 32;
    // Fine angle magnitude: up to a little over 180 degree in 2^-(F+8) units.
    localparam int FQ_W            = ANGLE_FRAC_BITS + 17;
    localparam int NUM_W           = ANGLE_FRAC_BITS + 60;
    localparam int RND_W           = FQ_W - 7;
    localparam int DEG_SCALE       = 180;

    typedef logic signed [63:0] t_word;
    typedef logic [47:0]        t_tag;

    localparam t_word ONE_Q60 = 64'sd1 <<< 60;

    // Machin's formula terms, each truncated as the series is summed.
    localparam t_word ATAN_INV5 =
          ONE_Q60 / (64'sd5 ** 1)  / 64'sd1  - ONE_Q60 / (64'sd5 ** 3)  / 64'sd3
        + ONE_Q60 / (64'sd5 ** 5)  / 64'sd5  - ONE_Q60 / (64'sd5 ** 7)  / 64'sd7
        + ONE_Q60 / (64'sd5 ** 9)  / 64'sd9  - ONE_Q60 / (64'sd5 ** 11) / 64'sd11
        + ONE_Q60 / (64'sd5 ** 13) / 64'sd13 - ONE_Q60 / (64'sd5 ** 15) / 64'sd15
        + ONE_Q60 / (64'sd5 ** 17) / 64'sd17 - ONE_Q60 / (64'sd5 ** 19) / 64'sd19
        + ONE_Q60 / (64'sd5 ** 21) / 64'sd21 - ONE_Q60 / (64'sd5 ** 23) / 64'sd23
        + ONE_Q60 / (64'sd5 ** 25) / 64'sd25;
    localparam t_word ATAN_INV239 =
          ONE_Q60 / (64'sd239 ** 1) / 64'sd1 - ONE_Q60 / (64'sd239 ** 3) / 64'sd3
        + ONE_Q60 / (64'sd239 ** 5) / 64'sd5 - ONE_Q60 / (64'sd239 ** 7) / 64'sd7;
    localparam t_word QUARTER = 4 * ATAN_INV5 - ATAN_INV239;
    localparam t_word PI_Q60  = 4 * QUARTER;
    localparam logic [63:0] DEG_DIV = 64'(PI_Q60 >>> 20);

    function automatic t_word pow_term(input int i, input int n);
        t_word t;
        t = '0;
        if (i * n <= 60) begin
            t = 64'sd1 <<< (60 - i * n);
        end
        return t;
    endfunction

    // atan(2^-i) from its power series, each term truncated.
    function automatic t_word step_angle(input int i);
        t_word s;
        if (i == 0) begin
            s = QUARTER;
        end else begin
            s = pow_term(i, 1) - pow_term(i, 3) / 3 + pow_term(i, 5) / 5
              - pow_term(i, 7) / 7 + pow_term(i, 9) / 9 - pow_term(i, 11) / 11
              + pow_term(i, 13) / 13 - pow_term(i, 15) / 15 + pow_term(i, 17) / 17
              - pow_term(i, 19) / 19 + pow_term(i, 21) / 21 - pow_term(i, 23) / 23
              + pow_term(i, 25) / 25 - pow_term(i, 27) / 27 + pow_term(i, 29) / 29
              - pow_term(i, 31) / 31 + pow_term(i, 33) / 33 - pow_term(i, 35) / 35
              + pow_term(i, 37) / 37 - pow_term(i, 39) / 39 + pow_term(i, 41) / 41
              - pow_term(i, 43) / 43 + pow_term(i, 45) / 45 - pow_term(i, 47) / 47
              + pow_term(i, 49) / 49 - pow_term(i, 51) / 51 + pow_term(i, 53) / 53
              - pow_term(i, 55) / 55 + pow_term(i, 57) / 57 - pow_term(i, 59) / 59;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/tilt_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_isqrt: pipelined integer square root
// A load stage and one cell per result bit; a tag travels with each value.
// ----------------------------------------------------------------------------
module tilt_isqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [63:0]     i_value,
    input  wire tilt_pkg::t_tag  i_tag,
    output logic                 o_valid,
    output logic [31:0]          o_root,
    output tilt_pkg::t_tag       o_tag
);

    localparam int STEPS = tilt_pkg::ROOT_STEPS;

    logic [63:0]    r_val  [0:STEPS];
    logic [63:0]    r_root [0:STEPS];
    tilt_pkg::t_tag r_tag  [0:STEPS];
    logic           r_v    [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_value;
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_cell
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] n_val;
        logic [63:0] n_root;
        logic [63:0] w_trial;

        always_comb begin
            w_trial = r_root[j] + BIT;
            n_val   = r_val[j];
            n_root  = r_root[j] >> 1;
            if (r_val[j] >= w_trial) begin
                n_val  = r_val[j] - w_trial;
                n_root = (r_root[j] >> 1) + BIT;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j + 1] <= 1'b0;
            end else if (i_en) begin
                r_v[j + 1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[j + 1]  <= n_val;
                r_root[j + 1] <= n_root;
                r_tag[j + 1]  <= r_tag[j];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_root  = r_root[STEPS][31:0];
    assign o_tag   = r_tag[STEPS];

endmodule
`default_nettype wire

// ===== design/tilt_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_cordic: pipelined vectoring CORDIC for atan2
// Half-plane fold, six normalising cells, one cell per rotation step.
// ----------------------------------------------------------------------------
module tilt_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire tilt_pkg::t_word i_x,
    input  wire tilt_pkg::t_word i_y,
    output logic                 o_valid,
    output tilt_pkg::t_word      o_theta
);

    localparam int NS   = tilt_pkg::NORM_STAGES;
    localparam int CS   = tilt_pkg::CORDIC_STEPS;
    localparam int LAST = NS + CS;

    tilt_pkg::t_word r_x   [0:LAST];
    tilt_pkg::t_word r_y   [0:LAST];
    tilt_pkg::t_word r_off [0:LAST];
    logic            r_zero[0:LAST];
    logic            r_v   [0:LAST];
    tilt_pkg::t_word r_mag [0:NS];
    tilt_pkg::t_word r_z   [1:CS];
    tilt_pkg::t_word r_theta;
    logic            r_vout;

    tilt_pkg::t_word n_x, n_y, n_off, n_mag, n_ay;
    logic            n_zero;

    // A vector in the left half plane is turned by pi first.
    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_off  = '0;
        n_zero = (i_x == '0) && (i_y == '0);
        if (i_x[63]) begin
            n_x   = -i_x;
            n_y   = -i_y;
            n_off = i_y[63] ? -tilt_pkg::PI_Q60 : tilt_pkg::PI_Q60;
        end
        n_ay  = n_y[63] ? -n_y : n_y;
        n_mag = (n_x > n_ay) ? n_x : n_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_off[0]  <= n_off;
            r_zero[0] <= n_zero;
            r_mag[0]  <= n_mag;
        end
    end

    // Binary search for the doubling count that brings the larger
    // coordinate into [2^59, 2^60).
    for (genvar k = 0; k < NS; k++) begin : g_norm
        localparam int              SH  = 32 >> k;
        localparam tilt_pkg::t_word LIM = 64'sd1 <<< (60 - SH);
        logic w_shift;

        assign w_shift = r_mag[k] < LIM;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k + 1] <= 1'b0;
            end else if (i_en) begin
                r_v[k + 1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k + 1]    <= w_shift ? (r_x[k] <<< SH) : r_x[k];
                r_y[k + 1]    <= w_shift ? (r_y[k] <<< SH) : r_y[k];
                r_mag[k + 1]  <= w_shift ? (r_mag[k] <<< SH) : r_mag[k];
                r_off[k + 1]  <= r_off[k];
                r_zero[k + 1] <= r_zero[k];
            end
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_step
        localparam tilt_pkg::t_word ANG = tilt_pkg::step_angle(i);
        tilt_pkg::t_word w_zin;
        tilt_pkg::t_word n_cx, n_cy, n_cz;

        if (i == 0) begin : g_first
            assign w_zin = '0;
        end else begin : g_rest
            assign w_zin = r_z[i];
        end

        always_comb begin
            if (r_y[NS + i] > 0) begin
                n_cx = r_x[NS + i] + (r_y[NS + i] >>> i);
                n_cy = r_y[NS + i] - (r_x[NS + i] >>> i);
                n_cz = w_zin + ANG;
            end else begin
                n_cx = r_x[NS + i] - (r_y[NS + i] >>> i);
                n_cy = r_y[NS + i] + (r_x[NS + i] >>> i);
                n_cz = w_zin - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[NS + i + 1] <= 1'b0;
            end else if (i_en) begin
                r_v[NS + i + 1] <= r_v[NS + i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[NS + i + 1]    <= n_cx;
                r_y[NS + i + 1]    <= n_cy;
                r_z[i + 1]         <= n_cz;
                r_off[NS + i + 1]  <= r_off[NS + i];
                r_zero[NS + i + 1] <= r_zero[NS + i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vout <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_theta <= r_zero[LAST] ? '0 : (r_z[CS] + r_off[LAST]);
        end
    end

    assign o_valid = r_vout;
    assign o_theta = r_theta;

endmodule
`default_nettype wire

// ===== design/tilt_degconv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_degconv: radians to fine degrees
// Scales by 180 and divides by pi with one restoring cell per quotient bit.
// ----------------------------------------------------------------------------
module tilt_degconv (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire tilt_pkg::t_word              i_theta,
    output logic                              o_valid,
    output logic                              o_neg,
    output logic [tilt_pkg::FQ_W-1:0]         o_mag
);

    localparam int QW = tilt_pkg::FQ_W;
    localparam int NW = tilt_pkg::NUM_W;

    logic [NW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic          r_v   [0:QW];

    logic [63:0]   n_u;
    logic [NW-1:0] n_num;

    always_comb begin
        n_u   = i_theta[63] ? 64'(-i_theta) : 64'(i_theta);
        n_num = (NW'(n_u[63:20]) * NW'(tilt_pkg::DEG_SCALE))
                << (tilt_pkg::ANGLE_FRAC_BITS + 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_q[0]   <= '0;
            r_neg[0] <= i_theta[63];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int            BIT = QW - 1 - j;
        localparam logic [NW-1:0] DSH = NW'(tilt_pkg::DEG_DIV) << BIT;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            n_rem = r_rem[j];
            n_q   = r_q[j];
            if (r_rem[j] >= DSH) begin
                n_rem    = r_rem[j] - DSH;
                n_q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j + 1] <= 1'b0;
            end else if (i_en) begin
                r_v[j + 1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j + 1] <= n_rem;
                r_q[j + 1]   <= n_q;
                r_neg[j + 1] <= r_neg[j];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_neg   = r_neg[QW];
    assign o_mag   = r_q[QW];

endmodule
`default_nettype wire

// ===== design/accel_tilt_angles.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angles: roll, pitch and ground angle from one accelerometer sample
//
// Input channel: i_valid / o_stall with the three raw axis samples. Output
// channel: o_valid / i_stall with roll, pitch and ground angle in units of
// 2^-ANGLE_FRAC_BITS degree, rounded to nearest.
// One transaction is taken every cycle while the output is not stalled.
// The data passes through the cell chains: a 32-cell square root, the CORDIC
// pair, the degree divider of ANGLE_FRAC_BITS + 18 stages and a second 32-cell
// square root. While a result waits with i_stall high the whole chain holds
// and o_stall is raised; nothing is dropped. Reset clears every valid flag,
// so the block comes out of reset empty and ready; payload registers are not
// reset.
// ----------------------------------------------------------------------------
module accel_tilt_angles (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic        [14:0]      o_ground_angle
);

    localparam int QW = tilt_pkg::FQ_W;
    localparam int RW = tilt_pkg::RND_W;

    logic w_en;

    logic               r_v0, r_v1;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic [31:0]        r_sy, r_sz;
    tilt_pkg::t_tag     r_tag1;

    logic           w_va;
    logic [31:0]    w_root_a;
    tilt_pkg::t_tag w_tag_a;

    logic            w_vr, w_vp;
    tilt_pkg::t_word w_th_r, w_th_p;
    tilt_pkg::t_word w_px, w_py;

    logic          w_dvr, w_dvp, w_neg_r, w_neg_p;
    logic [QW-1:0] w_mag_r, w_mag_p;

    logic [RW-1:0] n_rnd_r, n_rnd_p;
    logic [31:0]   n_roll, n_pitch;

    logic            r_vf;
    logic [15:0]     r_roll_f;
    logic [14:0]     r_pitch_f;
    logic [2*QW-1:0] r_sqr, r_sqp;

    logic           w_vb;
    logic [31:0]    w_root_b;
    tilt_pkg::t_tag w_tag_b;
    logic [32:0]    w_gr;

    logic        r_vout;
    logic [15:0] r_roll;
    logic [14:0] r_pitch;
    logic [14:0] r_ground;

    // The chain only moves when the output register is free to take a result.
    assign w_en    = !(r_vout && i_stall);
    assign o_stall = r_vout && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax   <= i_accel_x;
            r_ay   <= i_accel_y;
            r_az   <= i_accel_z;
            r_sy   <= 32'(r_ay * r_ay);
            r_sz   <= 32'(r_az * r_az);
            r_tag1 <= {r_ax, r_ay, r_az};
        end
    end

    // Radius with 16 fraction bits for the pitch denominator.
    tilt_isqrt u_root_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v1),
        .i_value ({r_sy + r_sz, 32'd0}),
        .i_tag   (r_tag1),
        .o_valid (w_va),
        .o_root  (w_root_a),
        .o_tag   (w_tag_a)
    );

    assign w_px = {32'd0, w_root_a};
    assign w_py = -(64'($signed(w_tag_a[47:32])) <<< 16);

    tilt_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_va),
        .i_x     (64'($signed(w_tag_a[15:0]))),
        .i_y     (64'($signed(w_tag_a[31:16]))),
        .o_valid (w_vr),
        .o_theta (w_th_r)
    );

    tilt_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_va),
        .i_x     (w_px),
        .i_y     (w_py),
        .o_valid (w_vp),
        .o_theta (w_th_p)
    );

    tilt_degconv u_deg_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vr),
        .i_theta (w_th_r),
        .o_valid (w_dvr),
        .o_neg   (w_neg_r),
        .o_mag   (w_mag_r)
    );

    tilt_degconv u_deg_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vp),
        .i_theta (w_th_p),
        .o_valid (w_dvp),
        .o_neg   (w_neg_p),
        .o_mag   (w_mag_p)
    );

    // Round half away from zero on the magnitude, then apply the sign.
    always_comb begin
        n_rnd_r = RW'(((QW + 1)'(w_mag_r) + (QW + 1)'(128)) >> 8);
        n_rnd_p = RW'(((QW + 1)'(w_mag_p) + (QW + 1)'(128)) >> 8);
        n_roll  = w_neg_r ? (32'd0 - 32'(n_rnd_r)) : 32'(n_rnd_r);
        n_pitch = w_neg_p ? (32'd0 - 32'(n_rnd_p)) : 32'(n_rnd_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (w_en) begin
            r_vf <= w_dvr && w_dvp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll_f  <= n_roll[15:0];
            r_pitch_f <= n_pitch[14:0];
            r_sqr     <= (2 * QW)'(w_mag_r) * (2 * QW)'(w_mag_r);
            r_sqp     <= (2 * QW)'(w_mag_p) * (2 * QW)'(w_mag_p);
        end
    end

    // Ground angle uses the unrounded fine angles.
    tilt_isqrt u_root_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vf),
        .i_value (64'(r_sqr) + 64'(r_sqp)),
        .i_tag   ({17'd0, r_roll_f, r_pitch_f}),
        .o_valid (w_vb),
        .o_root  (w_root_b),
        .o_tag   (w_tag_b)
    );

    assign w_gr = 33'(w_root_b) + 33'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (w_en) begin
            r_vout <= w_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll   <= w_tag_b[30:15];
            r_pitch  <= w_tag_b[14:0];
            r_ground <= w_gr[22:8];
        end
    end

    assign o_valid        = r_vout;
    assign o_roll_angle   = $signed(r_roll);
    assign o_pitch_angle  = $signed(r_pitch);
    assign o_ground_angle = r_ground;

`ifndef SYNTHESIS
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("waiting result was lost");

    a_cordic_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vr == w_vp)
        else $error("roll and pitch CORDIC chains out of step");

    a_degconv_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvr == w_dvp)
        else $error("roll and pitch degree converters out of step");
`endif

endmodule
`default_nettype wire

// ===== test/accel_tilt_angles_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angles_tb: self-checking bench for the tilt angle pipeline
// A short table of directed samples is followed by random samples. Every
// sample whose row has no typed angles is run through a bit-exact software
// CORDIC here, and each output transaction is compared with the oldest
// prediction. The sender bursts and pauses while the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module accel_tilt_angles_tb;

    localparam int ITERS      = 60;
    localparam int FRAC       = tilt_pkg::ANGLE_FRAC_BITS;
    localparam int N_RANDOM   = 1450;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 250;
    localparam int N_DIRECTED = 20;

    // Directed rows: x, y, z, typed, roll, pitch, ground.
    localparam int DIRECTED [N_DIRECTED][7] = '{
        // Zero vector, axis-aligned samples and the negative z axis, then full-scale and mixed samples.
        '{0, 0, 0, 1, 0, 0, 0},
        '{0, 0, 16384, 1, 0, 0, 0},
        '{0, 0, -16384, 1, 23040, 0, 23040},
        '{0, 0, -32768, 1, 23040, 0, 23040},
        '{16384, 0, 0, 1, 0, -11520, 11520},
        '{-16384, 0, 0, 1, 0, 11520, 11520},
        '{32767, 0, 0, 1, 0, -11520, 11520},
        '{-32768, 0, 0, 1, 0, 11520, 11520},
        '{0, 0, 1, 1, 0, 0, 0},
        '{0, 1, 0, 0, 0, 0, 0},
        '{0, -1, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0, 0},
        '{32767, 32767, 32767, 0, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0, 0},
        '{32767, -32768, 32767, 0, 0, 0, 0},
        '{-32768, 32767, -32768, 0, 0, 0, 0},
        '{0, 32767, -32768, 0, 0, 0, 0},
        '{0, -32768, -32768, 0, 0, 0, 0},
        '{1000, -1, -30000, 0, 0, 0, 0},
        '{-5, 3, 4, 0, 0, 0, 0}
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic        [14:0] ground;
    } t_angles;

    typedef struct packed {
        t_sample s;
        bit      typed;
        t_angles a;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_accel_x;
    logic signed [15:0] i_accel_y;
    logic signed [15:0] i_accel_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic        [14:0] o_ground_angle;

    accel_tilt_angles i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_roll_angle   (o_roll_angle),
        .o_pitch_angle  (o_pitch_angle),
        .o_ground_angle (o_ground_angle)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Arctangent steps and pi, 60 fraction bits.
    longint atan_step[ITERS];
    longint pi_fix;

    t_row    stim_q[$];
    t_angles angles_q[$];
    int      n_sent;
    int      n_checked;
    int      n_mismatch;
    int      n_cycles;
    bit      running;
    bit      hold_done;

    function automatic longint machin_term(longint unsigned n);
        longint unsigned p;
        longint unsigned nn;
        longint          acc;
        longint unsigned k;
        p   = (64'd1 << 60) / n;
        nn  = n * n;
        acc = 0;
        k   = 0;
        while (p != 0) begin
            acc = (k[0]) ? acc - longint'(p / (2 * k + 1)) : acc + longint'(p / (2 * k + 1));
            p   = p / nn;
            k++;
        end
        return acc;
    endfunction

    task automatic build_angle_tables();
        longint quarter;
        longint acc;
        int     k;
        quarter      = 4 * machin_term(5) - machin_term(239);
        pi_fix       = 4 * quarter;
        atan_step[0] = quarter;
        for (int i = 1; i < ITERS; i++) begin
            acc = 0;
            k   = 0;
            while (i * (2 * k + 1) <= 60) begin
                acc = (k % 2) ? acc - (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1)
                              : acc + (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
                k++;
            end
            atan_step[i] = acc;
        end
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint vy, longint vx);
        longint base;
        longint acc;
        longint dx;
        longint dy;
        base = 0;
        acc  = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            base = (vy >= 0) ? pi_fix : -pi_fix;
            vx   = -vx;
            vy   = -vy;
        end
        while (vx < (64'sd1 <<< 59) && vy < (64'sd1 <<< 59) && vy > -(64'sd1 <<< 59)) begin
            vx = vx * 2;
            vy = vy * 2;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + atan_step[i];
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - atan_step[i];
            end
        end
        return acc + base;
    endfunction

    // Radians to units of 2^-(FRAC + 8) degree.
    function automatic longint fine_degrees(longint theta);
        longint unsigned mag;
        longint unsigned m;
        longint unsigned d;
        longint unsigned q;
        mag = (theta < 0) ? longint'(-theta) : theta;
        m   = ((mag >> 20) * 180) << FRAC;
        d   = longint'(pi_fix) >> 20;
        q   = (m / d) * 256 + ((m % d) * 256) / d;
        return (theta < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_fine(longint f);
        if (f < 0) return -((-f + 128) >>> 8);
        return (f + 128) >>> 8;
    endfunction

    function automatic t_angles tilt_of(t_sample s);
        t_angles         a;
        longint          fr;
        longint          fp;
        longint          radius;
        longint unsigned mr;
        longint unsigned mp;
        longint          sy;
        longint          sz;
        longint          sx;
        longint          rr;
        longint          rp;
        sx     = s.x;
        sy     = s.y;
        sz     = s.z;
        fr     = fine_degrees(vector_angle(sy, sz));
        radius = int_sqrt(longint'(sy * sy + sz * sz) << 32);
        fp     = fine_degrees(vector_angle(-sx * 65536, radius));
        mr     = (fr < 0) ? -fr : fr;
        mp     = (fp < 0) ? -fp : fp;
        rr     = round_fine(fr);
        rp     = round_fine(fp);
        a.roll   = rr[15:0];
        a.pitch  = rp[14:0];
        a.ground = 15'((int_sqrt(mr * mr + mp * mp) + 128) >> 8);
        return a;
    endfunction

    task automatic add_row(int x, int y, int z, bit typed, int r, int p, int g);
        t_row row;
        row.s.x      = 16'(x);
        row.s.y      = 16'(y);
        row.s.z      = 16'(z);
        row.typed    = typed;
        row.a.roll   = 16'(r);
        row.a.pitch  = 15'(p);
        row.a.ground = 15'(g);
        stim_q.push_back(row);
    endtask

    function automatic logic signed [15:0] rand_axis();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($urandom_range(0, 8)) - 16'sd4;
            3:       return 16'sd0;
            4, 5:    return 16'($urandom_range(0, 2000)) - 16'sd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sender: bursts of transactions separated by gaps, one hold-off midway.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        t_row nxt;
        if (!running) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) n_sent++;
            if (i_valid && o_stall) begin
                // held payload stays put
            end else if (!hold_done && n_sent >= 700 && angles_q.size() != 0) begin
                i_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                if (n_sent >= 700) hold_done = 1'b1;
                nxt = stim_q.pop_front();
                angles_q.push_back(nxt.typed ? nxt.a : tilt_of(nxt.s));
                i_valid   <= 1'b1;
                i_accel_x <= nxt.s.x;
                i_accel_y <= nxt.s.y;
                i_accel_z <= nxt.s.z;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: phases of no stall, light stall and heavy stall.
    int stall_phase;
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles % 300 == 0) stall_phase = $urandom_range(0, 2);
        case (stall_phase)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 9) < 3);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
        if (n_cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Checker for each output transaction.
    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angles_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %0d %0d %0d",
                    o_roll_angle, o_pitch_angle, o_ground_angle);
            end else begin
                want = angles_q.pop_front();
                n_checked++;
                if (o_roll_angle !== want.roll || o_pitch_angle !== want.pitch
                        || o_ground_angle !== want.ground) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: roll %0d/%0d pitch %0d/%0d ground %0d/%0d",
                            n_checked, want.roll, o_roll_angle, want.pitch,
                            o_pitch_angle, want.ground, o_ground_angle);
                end
            end
        end
    end

    initial begin
        t_sample s;
        running    = 1'b0;
        hold_done  = 1'b0;
        n_sent     = 0;
        n_checked  = 0;
        n_mismatch = 0;
        n_cycles   = 0;
        burst_left = 0;
        gap_left   = 0;
        stall_phase = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_accel_x  = '0;
        i_accel_y  = '0;
        i_accel_z  = '0;
        build_angle_tables();

        for (int i = 0; i < N_DIRECTED; i++) begin
            add_row(DIRECTED[i][0], DIRECTED[i][1], DIRECTED[i][2], DIRECTED[i][3] != 0,
                DIRECTED[i][4], DIRECTED[i][5], DIRECTED[i][6]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            s.x = rand_axis();
            s.y = rand_axis();
            s.z = rand_axis();
            add_row(s.x, s.y, s.z, 0, 0, 0, 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;

        wait (stim_q.size() == 0 && !(i_valid && o_stall));
        @(posedge i_clk);
        wait (angles_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d samples sent, %0d results checked with stalls, gaps and a drain pause",
            n_sent, n_checked);
        if (n_mismatch == 0 && angles_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, angles_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/tilt_pkg.sv
design/tilt_isqrt.sv
design/tilt_cordic.sv
design/tilt_degconv.sv
design/accel_tilt_angles.sv
test/accel_tilt_angles_tb.sv
